// ----- rtl/core/bcst_pkg.sv -----
// Shared types and constants for the battery charge state tracker.
package bcst_pkg;

    localparam int POWER_W    = 24;
    localparam int SOC_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CAP_W      = 16;
    localparam int STEP_W     = 16;
    localparam int VOLTS_W    = 10;

    localparam int DIVIDEND_W  = 72;
    localparam int DIVISOR_W   = 56;
    localparam int DIV_SHORT_W = 32;
    localparam int DIV_CNT_W   = 7;

    localparam int EXP_ITERATIONS = 16;

    localparam logic [SOC_W-1:0] FULL_Q = 32'd3355443200;
    localparam logic [SOC_W-1:0] HALF_Q = 32'd1677721600;
    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
    localparam logic [31:0] SLOPE_Q16   = 32'd13586;
    localparam logic [43:0] OFFSET_Q16  = 44'd36045;
    localparam logic [31:0] INV_E_Q30   = 32'd395007542;
    localparam logic [46:0] POWER_FLOOR = 47'd100;

    localparam logic [CAP_W-1:0]   CAP_RESET   = 16'd800;
    localparam logic [STEP_W-1:0]  STEP_RESET  = 16'd60;
    localparam logic [VOLTS_W-1:0] VOLTS_RESET = 10'd48;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAPACITY = 2'd0,
        REG_STEP     = 2'd1,
        REG_VOLTS    = 2'd2
    } reg_idx_t;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_PREP,
        CMD_CALC_A,
        CMD_LIM_MUL,
        CMD_LIM_DIV,
        CMD_LIM_SET,
        CMD_DEN_DIV,
        CMD_DEN_SET,
        CMD_U_DIV,
        CMD_U_SET,
        CMD_T_MUL,
        CMD_T_DIV,
        CMD_T_SET,
        CMD_T_CLAMP,
        CMD_E_MUL,
        CMD_BASE,
        CMD_P_LO,
        CMD_P_HI,
        CMD_D_SHIFT,
        CMD_DELTA_DIV,
        CMD_FINISH
    } cmd_t;

    typedef struct packed {
        logic div_busy;
        logic discharge;
        logic term_last;
        logic chain_done;
        logic out_free;
    } stat_t;

endpackage

// ----- rtl/core/bcst_if.sv -----
// Valid/ready channel interfaces for input and result beats.
interface bcst_in_if;
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [bcst_pkg::POWER_W-1:0] power_request;

    modport source (output valid, output func, output power_request, input ready);
    modport sink   (input valid, input func, input power_request, output ready);
endinterface

interface bcst_out_if;
    logic                         valid;
    logic                         ready;
    logic [bcst_pkg::POWER_W-1:0] power_moved;
    logic [bcst_pkg::SOC_W-1:0]   soc_percent;

    modport source (output valid, output power_moved, output soc_percent, input ready);
    modport sink   (input valid, input power_moved, input soc_percent, output ready);
endinterface

// ----- rtl/core/bcst_div.sv -----
// Restoring divider, one quotient bit per cycle, full or short dividend.
module bcst_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            short_mode,
    input  logic [bcst_pkg::DIVIDEND_W-1:0] dividend,
    input  logic [bcst_pkg::DIVISOR_W-1:0]  divisor,
    output logic                            busy,
    output logic [bcst_pkg::DIVIDEND_W-1:0] quotient
);

    localparam int DW = bcst_pkg::DIVIDEND_W;
    localparam int RW = bcst_pkg::DIVISOR_W + 1;

    logic [DW-1:0]                     quo_reg;
    logic [RW-1:0]                     rem_reg;
    logic [bcst_pkg::DIVISOR_W-1:0]    dsr_reg;
    logic [bcst_pkg::DIV_CNT_W-1:0]    cnt_reg;
    logic                              busy_reg;
    logic [RW-1:0]                     rem_sh;
    logic [RW-1:0]                     rem_sub;
    logic                              fits;

    assign rem_sh  = {rem_reg[RW-2:0], quo_reg[DW-1]};
    assign fits    = rem_sh >= {1'b0, dsr_reg};
    assign rem_sub = rem_sh - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= short_mode ? bcst_pkg::DIV_CNT_W'(bcst_pkg::DIV_SHORT_W)
                                   : bcst_pkg::DIV_CNT_W'(DW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - bcst_pkg::DIV_CNT_W'(1);
            if (cnt_reg == bcst_pkg::DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= short_mode
                ? {dividend[bcst_pkg::DIV_SHORT_W-1:0], {(DW-bcst_pkg::DIV_SHORT_W){1'b0}}}
                : dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DW-2:0], fits};
            rem_reg <= fits ? rem_sub : rem_sh;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ----- rtl/core/bcst_ctrl.sv -----
// Sequencer that steps the datapath through one time step per item.
module bcst_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  bcst_pkg::stat_t stat,
    output bcst_pkg::cmd_t  cmd
);

    typedef enum logic [25:0] {
        ST_IDLE       = 26'b1 << 0,
        ST_PREP       = 26'b1 << 1,
        ST_CALC_A     = 26'b1 << 2,
        ST_LIM_MUL    = 26'b1 << 3,
        ST_LIM_DIV    = 26'b1 << 4,
        ST_LIM_WAIT   = 26'b1 << 5,
        ST_LIM_SET    = 26'b1 << 6,
        ST_DEN_DIV    = 26'b1 << 7,
        ST_DEN_WAIT   = 26'b1 << 8,
        ST_DEN_SET    = 26'b1 << 9,
        ST_U_DIV      = 26'b1 << 10,
        ST_U_WAIT     = 26'b1 << 11,
        ST_U_SET      = 26'b1 << 12,
        ST_T_MUL      = 26'b1 << 13,
        ST_T_DIV      = 26'b1 << 14,
        ST_T_WAIT     = 26'b1 << 15,
        ST_T_SET      = 26'b1 << 16,
        ST_T_CLAMP    = 26'b1 << 17,
        ST_E_MUL      = 26'b1 << 18,
        ST_BASE       = 26'b1 << 19,
        ST_P_LO       = 26'b1 << 20,
        ST_P_HI       = 26'b1 << 21,
        ST_D_SHIFT    = 26'b1 << 22,
        ST_DELTA_DIV  = 26'b1 << 23,
        ST_DELTA_WAIT = 26'b1 << 24,
        ST_FINISH     = 26'b1 << 25
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = bcst_pkg::CMD_NONE;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd        = bcst_pkg::CMD_LOAD;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd        = bcst_pkg::CMD_PREP;
                state_next = ST_CALC_A;
            end
            ST_CALC_A:
            begin
                cmd        = bcst_pkg::CMD_CALC_A;
                state_next = ST_LIM_MUL;
            end
            ST_LIM_MUL:
            begin
                cmd        = bcst_pkg::CMD_LIM_MUL;
                state_next = ST_LIM_DIV;
            end
            ST_LIM_DIV:
            begin
                cmd        = bcst_pkg::CMD_LIM_DIV;
                state_next = ST_LIM_WAIT;
            end
            ST_LIM_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    state_next = ST_LIM_SET;
                end
            end
            ST_LIM_SET:
            begin
                cmd        = bcst_pkg::CMD_LIM_SET;
                state_next = stat.discharge ? ST_BASE : ST_DEN_DIV;
            end
            ST_DEN_DIV:
            begin
                cmd        = bcst_pkg::CMD_DEN_DIV;
                state_next = ST_DEN_WAIT;
            end
            ST_DEN_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    state_next = ST_DEN_SET;
                end
            end
            ST_DEN_SET:
            begin
                cmd        = bcst_pkg::CMD_DEN_SET;
                state_next = ST_U_DIV;
            end
            ST_U_DIV:
            begin
                cmd        = bcst_pkg::CMD_U_DIV;
                state_next = ST_U_WAIT;
            end
            ST_U_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    state_next = ST_U_SET;
                end
            end
            ST_U_SET:
            begin
                cmd        = bcst_pkg::CMD_U_SET;
                state_next = ST_T_MUL;
            end
            ST_T_MUL:
            begin
                cmd        = bcst_pkg::CMD_T_MUL;
                state_next = ST_T_DIV;
            end
            ST_T_DIV:
            begin
                cmd        = bcst_pkg::CMD_T_DIV;
                state_next = ST_T_WAIT;
            end
            ST_T_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    state_next = ST_T_SET;
                end
            end
            ST_T_SET:
            begin
                cmd        = bcst_pkg::CMD_T_SET;
                state_next = stat.term_last ? ST_T_CLAMP : ST_T_MUL;
            end
            ST_T_CLAMP:
            begin
                cmd        = bcst_pkg::CMD_T_CLAMP;
                state_next = ST_E_MUL;
            end
            ST_E_MUL:
            begin
                if (stat.chain_done)
                begin
                    state_next = ST_BASE;
                end
                else
                begin
                    cmd = bcst_pkg::CMD_E_MUL;
                end
            end
            ST_BASE:
            begin
                cmd        = bcst_pkg::CMD_BASE;
                state_next = stat.discharge ? ST_D_SHIFT : ST_P_LO;
            end
            ST_P_LO:
            begin
                cmd        = bcst_pkg::CMD_P_LO;
                state_next = ST_P_HI;
            end
            ST_P_HI:
            begin
                cmd        = bcst_pkg::CMD_P_HI;
                state_next = ST_DELTA_DIV;
            end
            ST_D_SHIFT:
            begin
                cmd        = bcst_pkg::CMD_D_SHIFT;
                state_next = ST_DELTA_DIV;
            end
            ST_DELTA_DIV:
            begin
                cmd        = bcst_pkg::CMD_DELTA_DIV;
                state_next = ST_DELTA_WAIT;
            end
            ST_DELTA_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                cmd = bcst_pkg::CMD_FINISH;
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/bcst_dp.sv -----
// Datapath: configuration, charge state, shared multiplier and divider, result register.
module bcst_dp #(
    parameter int EXP_ITERATIONS = bcst_pkg::EXP_ITERATIONS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  bcst_pkg::cmd_t                  cmd,
    output bcst_pkg::stat_t                 stat,
    input  logic                            in_func,
    input  logic [bcst_pkg::POWER_W-1:0]    in_power,
    input  logic                            cfg_wen,
    input  logic [bcst_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bcst_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [bcst_pkg::POWER_W-1:0]    out_power,
    output logic [bcst_pkg::SOC_W-1:0]      out_soc
);

    localparam int KW = $clog2(EXP_ITERATIONS + 1);
    localparam int DW = bcst_pkg::DIVIDEND_W;

    logic [bcst_pkg::CAP_W-1:0]   cap_reg;
    logic [bcst_pkg::STEP_W-1:0]  stp_reg;
    logic [bcst_pkg::VOLTS_W-1:0] volts_reg;
    logic [bcst_pkg::SOC_W-1:0]   soc_reg;
    logic                         out_valid_reg;

    logic                         func_reg;
    logic [bcst_pkg::POWER_W-1:0] p_reg;
    logic [25:0]                  vc_reg;
    logic [31:0]                  a_reg;
    logic [31:0]                  diff_reg;
    logic [bcst_pkg::POWER_W-1:0] moved_reg;
    logic [DW-1:0]                prod_reg;
    logic [43:0]                  den_reg;
    logic [5:0]                   n_reg;
    logic [15:0]                  f_reg;
    logic [30:0]                  t_reg;
    logic signed [32:0]           sum_reg;
    logic [KW-1:0]                k_reg;
    logic [30:0]                  r_reg;
    logic [4:0]                   ncnt_reg;
    logic [39:0]                  base_reg;
    logic [30:0]                  eta_reg;
    logic [bcst_pkg::POWER_W-1:0] out_power_reg;
    logic [bcst_pkg::SOC_W-1:0]   out_soc_reg;

    logic [bcst_pkg::CAP_W-1:0]   cap_eff;
    logic [bcst_pkg::STEP_W-1:0]  stp_eff;
    logic [bcst_pkg::VOLTS_W-1:0] volts_eff;
    logic [31:0]                  mul_a;
    logic [31:0]                  mul_b;
    logic [63:0]                  mul_res;
    logic                         div_start;
    logic                         div_short;
    logic [DW-1:0]                div_dividend;
    logic [bcst_pkg::DIVISOR_W-1:0] div_divisor;
    logic                         div_busy;
    logic [DW-1:0]                quo;
    logic [46:0]                  limit;
    logic [46:0]                  limit_c;
    logic [27:0]                  moved_x10;
    logic [67:0]                  charge_sum;
    logic [bcst_pkg::SOC_W-1:0]   soc_next;
    logic                         out_free;
    logic                         finish;

    assign cap_eff   = (cap_reg == '0) ? bcst_pkg::CAP_W'(1) : cap_reg;
    assign stp_eff   = (stp_reg == '0) ? bcst_pkg::STEP_W'(1) : stp_reg;
    assign volts_eff = (volts_reg == '0) ? bcst_pkg::VOLTS_W'(1) : volts_reg;

    assign out_free = !out_valid_reg || out_ready;
    assign finish   = (cmd == bcst_pkg::CMD_FINISH) && out_free;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd)
            bcst_pkg::CMD_PREP:
            begin
                mul_a = 32'(cap_eff);
                mul_b = 32'(volts_eff);
            end
            bcst_pkg::CMD_LIM_MUL:
            begin
                mul_a = func_reg ? soc_reg : diff_reg;
                mul_b = a_reg;
            end
            bcst_pkg::CMD_DEN_SET:
            begin
                mul_a = diff_reg;
                mul_b = bcst_pkg::SLOPE_Q16;
            end
            bcst_pkg::CMD_T_MUL:
            begin
                mul_a = 32'(t_reg);
                mul_b = {2'b0, f_reg, 14'b0};
            end
            bcst_pkg::CMD_E_MUL:
            begin
                mul_a = 32'(r_reg);
                mul_b = bcst_pkg::INV_E_Q30;
            end
            bcst_pkg::CMD_BASE:
            begin
                mul_a = 32'(moved_reg);
                mul_b = 32'(stp_eff);
            end
            bcst_pkg::CMD_P_LO:
            begin
                mul_a = base_reg[31:0];
                mul_b = 32'(eta_reg);
            end
            bcst_pkg::CMD_P_HI:
            begin
                mul_a = 32'(base_reg[39:32]);
                mul_b = 32'(eta_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_res = 64'(mul_a) * 64'(mul_b);

    assign moved_x10 = {1'b0, moved_reg, 3'b0} + {3'b0, moved_reg, 1'b0};

    always_comb
    begin
        div_start    = 1'b0;
        div_short    = 1'b0;
        div_dividend = prod_reg;
        div_divisor  = '0;
        case (cmd)
            bcst_pkg::CMD_LIM_DIV:
            begin
                div_start   = 1'b1;
                div_divisor = bcst_pkg::DIVISOR_W'(stp_eff);
            end
            bcst_pkg::CMD_DEN_DIV:
            begin
                div_start    = 1'b1;
                div_dividend = DW'({moved_x10, 16'b0});
                div_divisor  = bcst_pkg::DIVISOR_W'(vc_reg);
            end
            bcst_pkg::CMD_U_DIV:
            begin
                div_start   = 1'b1;
                div_divisor = bcst_pkg::DIVISOR_W'({den_reg, 9'b0});
            end
            bcst_pkg::CMD_T_DIV:
            begin
                div_start    = 1'b1;
                div_short    = 1'b1;
                div_dividend = DW'(prod_reg[59:30]);
                div_divisor  = bcst_pkg::DIVISOR_W'(k_reg);
            end
            bcst_pkg::CMD_DELTA_DIV:
            begin
                div_start   = 1'b1;
                div_divisor = bcst_pkg::DIVISOR_W'(a_reg);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    bcst_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .short_mode (div_short),
        .dividend   (div_dividend),
        .divisor    (div_divisor),
        .busy       (div_busy),
        .quotient   (quo)
    );

    assign limit   = quo[DW-1:25];
    assign limit_c = (!func_reg && (limit <= bcst_pkg::POWER_FLOOR))
                     ? bcst_pkg::POWER_FLOOR : limit;

    assign charge_sum = 68'(soc_reg) + 68'(quo[DW-1:5]);

    always_comb
    begin
        if (func_reg)
        begin
            soc_next = (quo >= DW'(soc_reg)) ? '0 : soc_reg - quo[31:0];
        end
        else
        begin
            soc_next = (charge_sum >= 68'(bcst_pkg::FULL_Q)) ? bcst_pkg::FULL_Q
                                                             : charge_sum[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= bcst_pkg::CAP_RESET;
            stp_reg       <= bcst_pkg::STEP_RESET;
            volts_reg     <= bcst_pkg::VOLTS_RESET;
            soc_reg       <= bcst_pkg::HALF_Q;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                unique case (bcst_pkg::reg_idx_t'(cfg_index))
                    bcst_pkg::REG_CAPACITY: cap_reg   <= cfg_wdata[bcst_pkg::CAP_W-1:0];
                    bcst_pkg::REG_STEP:     stp_reg   <= cfg_wdata[bcst_pkg::STEP_W-1:0];
                    bcst_pkg::REG_VOLTS:    volts_reg <= cfg_wdata[bcst_pkg::VOLTS_W-1:0];
                    default:                cap_reg   <= cap_reg;
                endcase
            end
            if (finish)
            begin
                soc_reg       <= soc_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd)
            bcst_pkg::CMD_LOAD:
            begin
                func_reg <= in_func;
                p_reg    <= in_power;
            end
            bcst_pkg::CMD_PREP:
            begin
                vc_reg   <= mul_res[25:0];
                diff_reg <= (soc_reg < bcst_pkg::FULL_Q) ? bcst_pkg::FULL_Q - soc_reg : '0;
            end
            bcst_pkg::CMD_CALC_A:
            begin
                a_reg <= {1'b0, vc_reg, 5'b0} + {4'b0, vc_reg, 2'b0};
            end
            bcst_pkg::CMD_LIM_MUL:
            begin
                prod_reg <= DW'(mul_res);
            end
            bcst_pkg::CMD_LIM_SET:
            begin
                moved_reg <= (47'(p_reg) >= limit_c) ? limit_c[bcst_pkg::POWER_W-1:0] : p_reg;
            end
            bcst_pkg::CMD_DEN_SET:
            begin
                den_reg  <= quo[43:0] + bcst_pkg::OFFSET_Q16;
                prod_reg <= DW'(mul_res);
            end
            bcst_pkg::CMD_U_SET:
            begin
                n_reg   <= quo[21:16];
                f_reg   <= quo[15:0];
                t_reg   <= bcst_pkg::ONE_Q30;
                sum_reg <= $signed({2'b0, bcst_pkg::ONE_Q30});
                k_reg   <= KW'(1);
            end
            bcst_pkg::CMD_T_MUL:
            begin
                prod_reg <= DW'(mul_res);
            end
            bcst_pkg::CMD_T_SET:
            begin
                t_reg   <= quo[30:0];
                sum_reg <= k_reg[0] ? sum_reg - $signed({2'b0, quo[30:0]})
                                    : sum_reg + $signed({2'b0, quo[30:0]});
                k_reg   <= k_reg + KW'(1);
            end
            bcst_pkg::CMD_T_CLAMP:
            begin
                if (n_reg[5] || sum_reg < 0)
                begin
                    r_reg <= '0;
                end
                else if (sum_reg > $signed({2'b0, bcst_pkg::ONE_Q30}))
                begin
                    r_reg <= bcst_pkg::ONE_Q30;
                end
                else
                begin
                    r_reg <= sum_reg[30:0];
                end
                ncnt_reg <= n_reg[5] ? 5'd0 : n_reg[4:0];
            end
            bcst_pkg::CMD_E_MUL:
            begin
                r_reg    <= mul_res[60:30];
                ncnt_reg <= ncnt_reg - 5'd1;
            end
            bcst_pkg::CMD_BASE:
            begin
                base_reg <= mul_res[39:0];
                eta_reg  <= bcst_pkg::ONE_Q30 - r_reg;
            end
            bcst_pkg::CMD_P_LO:
            begin
                prod_reg <= DW'(mul_res);
            end
            bcst_pkg::CMD_P_HI:
            begin
                prod_reg <= prod_reg + DW'({mul_res[38:0], 32'b0});
            end
            bcst_pkg::CMD_D_SHIFT:
            begin
                prod_reg <= DW'({base_reg, 25'b0});
            end
            default:
            begin
                t_reg <= t_reg;
            end
        endcase
        if (finish)
        begin
            out_power_reg <= moved_reg;
            out_soc_reg   <= soc_next;
        end
    end

    assign stat.div_busy   = div_busy;
    assign stat.discharge  = func_reg;
    assign stat.term_last  = (k_reg == KW'(EXP_ITERATIONS));
    assign stat.chain_done = (ncnt_reg == 5'd0);
    assign stat.out_free   = out_free;

    assign out_valid = out_valid_reg;
    assign out_power = out_power_reg;
    assign out_soc   = out_soc_reg;

endmodule

// ----- rtl/core/battery_charge_state_tracker.sv -----
// Top level of the lead-acid battery charge state tracker.
//
//  channel  | direction | beat content
//  ---------+-----------+--------------------------------------------
//  in_ch    | sink      | func, power_request
//  out_ch   | source    | power_moved, soc_percent
//  cfg      | write     | cfg_wen, cfg_index, cfg_wdata
//
// One item at a time; a shared restoring divider (72 quotient bits, 32 for a
// series term) works each division, and a charge also runs the series and
// a chain of multiplications by 1/e, as many as the integer part of u (none
// when it is 32 or more).
// Reset clears the charge state to 50 percent and the registers to defaults.
// A result waiting in the output register does not block the next item;
// only the final write of the following item waits for it to be taken.
module battery_charge_state_tracker #(
    parameter int EXP_ITERATIONS = bcst_pkg::EXP_ITERATIONS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    bcst_in_if.sink                         in_ch,
    bcst_out_if.source                      out_ch,
    input  logic                            cfg_wen,
    input  logic [bcst_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bcst_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    bcst_pkg::cmd_t  cmd;
    bcst_pkg::stat_t stat;

    bcst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bcst_dp #(
        .EXP_ITERATIONS (EXP_ITERATIONS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_func   (in_ch.func),
        .in_power  (in_ch.power_request),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .out_power (out_ch.power_moved),
        .out_soc   (out_ch.soc_percent)
    );

endmodule

// ----- rtl/core/bcst_checker.sv -----
// Port-level checks for the charge state tracker, bound to the top level.
module bcst_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [bcst_pkg::SOC_W-1:0]   out_soc
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    a_soc_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_soc))
        else $error("stalled result changed");

    a_soc_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_soc <= bcst_pkg::FULL_Q)
        else $error("state of charge above full");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("new item taken while one is in work");

endmodule

bind battery_charge_state_tracker bcst_checker u_bcst_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_soc   (out_ch.soc_percent)
);

// ----- dv/battery_soc_checker.sv -----
// Checker that predicts and compares every result beat of the charge state tracker.
`timescale 1ns / 100ps

module battery_soc_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    bcst_in_if                              in_mon,
    bcst_out_if                             out_mon,
    input  logic                            cfg_wen,
    input  logic [bcst_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bcst_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                              fail_count,
    output int                              outstanding
);

    typedef longint unsigned u64_t;

    typedef struct {
        logic [bcst_pkg::POWER_W-1:0] moved;
        logic [bcst_pkg::SOC_W-1:0]   soc;
    } soc_result_t;

    localparam u64_t SAT_Q62 = u64_t'(1) << 62;

    logic [bcst_pkg::CAP_W-1:0]   capacity;
    logic [bcst_pkg::STEP_W-1:0]  step_len;
    logic [bcst_pkg::VOLTS_W-1:0] volts_nom;
    logic [bcst_pkg::SOC_W-1:0]   charge_level;
    soc_result_t                  soc_results_q[$];

    assign outstanding = soc_results_q.size();

    task automatic report(input string field, input u64_t got, input u64_t want);
        $display("tb: mismatch on %s: got %0d, want %0d at %0t", field, got, want, $time);
        fail_count++;
    endtask

    function automatic u64_t scaled_quotient(u64_t base, u64_t mul, u64_t den, int rs);
        u64_t q;
        u64_t r;
        u64_t x;
        q = base / den;
        r = base % den;
        if (mul != 0 && q > SAT_Q62 / mul)
            return SAT_Q62;
        x = q * mul + (r * mul) / den;
        x = x >> rs;
        return (x > SAT_Q62) ? SAT_Q62 : x;
    endfunction

    function automatic u64_t exp_decay(u64_t u);
        u64_t    n;
        u64_t    f;
        u64_t    t;
        u64_t    r;
        longint  sum;
        n = u >> 16;
        f = (u & 64'hFFFF) << 14;
        t = u64_t'(bcst_pkg::ONE_Q30);
        sum = longint'(bcst_pkg::ONE_Q30);
        if (n >= 32)
            return 0;
        for (int k = 1; k <= bcst_pkg::EXP_ITERATIONS; k++)
        begin
            t = ((t * f) >> 30) / u64_t'(k);
            if (k % 2 == 1)
                sum = sum - longint'(t);
            else
                sum = sum + longint'(t);
        end
        if (sum < 0)
            sum = 0;
        if (sum > longint'(bcst_pkg::ONE_Q30))
            sum = longint'(bcst_pkg::ONE_Q30);
        r = u64_t'(sum);
        for (u64_t i = 0; i < n; i++)
            r = (r * u64_t'(bcst_pkg::INV_E_Q30)) >> 30;
        return r;
    endfunction

    function automatic soc_result_t advance_charge(logic func,
                                                   logic [bcst_pkg::POWER_W-1:0] p);
        soc_result_t res;
        u64_t cap;
        u64_t stp;
        u64_t vlt;
        u64_t a;
        u64_t soc;
        u64_t diff;
        u64_t lim;
        u64_t moved;
        u64_t den;
        u64_t u;
        u64_t eta;
        u64_t delta;
        u64_t next;
        cap = (capacity == 0) ? 1 : u64_t'(capacity);
        stp = (step_len == 0) ? 1 : u64_t'(step_len);
        vlt = (volts_nom == 0) ? 1 : u64_t'(volts_nom);
        a = cap * 36 * vlt;
        soc = u64_t'(charge_level);
        if (func == 1'b0)
        begin
            diff = (soc < u64_t'(bcst_pkg::FULL_Q)) ? u64_t'(bcst_pkg::FULL_Q) - soc : 0;
            lim = ((diff * a) / stp) >> 25;
            if (lim <= 100)
                lim = 100;
            moved = (u64_t'(p) >= lim) ? lim : u64_t'(p);
            den = ((moved * 10) << 16) / (vlt * cap) + u64_t'(bcst_pkg::OFFSET_Q16);
            u = (diff * u64_t'(bcst_pkg::SLOPE_Q16)) / (den * 512);
            eta = u64_t'(bcst_pkg::ONE_Q30) - exp_decay(u);
            delta = scaled_quotient(moved * stp, eta, a, 5);
            next = soc + delta;
            if (next >= u64_t'(bcst_pkg::FULL_Q))
                next = u64_t'(bcst_pkg::FULL_Q);
        end
        else
        begin
            lim = ((soc * a) / stp) >> 25;
            moved = (u64_t'(p) >= lim) ? lim : u64_t'(p);
            delta = scaled_quotient(moved * stp, u64_t'(1) << 25, a, 0);
            next = (delta >= soc) ? 0 : soc - delta;
        end
        charge_level = next[bcst_pkg::SOC_W-1:0];
        res.moved = (moved > 64'hFFFFFF) ? 24'hFFFFFF : moved[bcst_pkg::POWER_W-1:0];
        res.soc = next[bcst_pkg::SOC_W-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        soc_result_t want;
        if (!rst_n)
        begin
            capacity = bcst_pkg::CAP_RESET;
            step_len = bcst_pkg::STEP_RESET;
            volts_nom = bcst_pkg::VOLTS_RESET;
            charge_level = bcst_pkg::HALF_Q;
            soc_results_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_index)
                    bcst_pkg::REG_CAPACITY: capacity = cfg_wdata;
                    bcst_pkg::REG_STEP:     step_len = cfg_wdata;
                    bcst_pkg::REG_VOLTS:    volts_nom = cfg_wdata[bcst_pkg::VOLTS_W-1:0];
                    default:                ;
                endcase
            end
            if (in_mon.valid && in_mon.ready)
                soc_results_q.push_back(advance_charge(in_mon.func, in_mon.power_request));
            if (out_mon.valid && out_mon.ready)
            begin
                if (soc_results_q.size() == 0)
                    report("unexpected beat", out_mon.soc_percent, 0);
                else
                begin
                    want = soc_results_q.pop_front();
                    if (out_mon.power_moved !== want.moved)
                        report("power_moved", out_mon.power_moved, want.moved);
                    if (out_mon.soc_percent !== want.soc)
                        report("soc_percent", out_mon.soc_percent, want.soc);
                end
            end
        end
    end

endmodule

// ----- dv/battery_charge_state_tracker_test.sv -----
// Stimulus and verdict for the battery charge state tracker.
`timescale 1ns / 100ps

module battery_charge_state_tracker_test;

    localparam logic [bcst_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_wen;
    logic [bcst_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [bcst_pkg::CFG_DATA_W-1:0] cfg_wdata;
    int                              fail_count;
    int                              outstanding;
    int                              hold_request;
    int                              beats_sent;
    int                              charges_sent;

    bcst_in_if  in_ch();
    bcst_out_if out_ch();

    battery_charge_state_tracker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    battery_soc_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_mon      (in_ch),
        .out_mon     (out_ch),
        .cfg_wen     (cfg_wen),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #60ms;
        $display("tb: failure");
        $finish;
    end

    task automatic send_beat(input logic func, input logic [bcst_pkg::POWER_W-1:0] p);
        int gap;
        gap = $urandom_range(0, 13);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.func = func;
        in_ch.power_request = p;
        in_ch.valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ch.ready);
        @(negedge clk);
        beats_sent++;
        if (func == 1'b0)
            charges_sent++;
    endtask

    task automatic drain;
        in_ch.valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(input logic [bcst_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bcst_pkg::CFG_DATA_W-1:0] val);
        cfg_index = idx;
        cfg_wdata = val;
        cfg_wen = 1'b1;
        @(negedge clk);
        cfg_wen = 1'b0;
    endtask

    task automatic configure(input int cap, input int stp, input int vlt);
        drain();
        write_reg(bcst_pkg::REG_CAPACITY, cap[15:0]);
        write_reg(bcst_pkg::REG_STEP, stp[15:0]);
        write_reg(bcst_pkg::REG_VOLTS, vlt[15:0]);
        write_reg(REG_UNUSED, 16'($urandom));
    endtask

    function automatic logic [bcst_pkg::POWER_W-1:0] random_power();
        case ($urandom_range(0, 3))
            0:       return 24'($urandom);
            1:       return 24'($urandom_range(0, 1000));
            2:       return 24'($urandom_range(0, 200000));
            default: return 24'($urandom_range(0, 3000000));
        endcase
    endfunction

    always
    begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                out_ch.ready = 1'b0;
                repeat (hold_request) @(negedge clk);
                hold_request = 0;
            end
            stall = $urandom_range(0, 13);
            if ($urandom_range(0, 3) == 0)
                stall = 0;
            if (stall > 0)
            begin
                out_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready = 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_wen = 1'b0;
        cfg_index = bcst_pkg::REG_CAPACITY;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.func = 1'b0;
        in_ch.power_request = '0;
        hold_request = 0;
        beats_sent = 0;
        charges_sent = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_beat(1'b0, 24'd0);
        send_beat(1'b1, 24'd0);
        send_beat(1'b1, 24'hFFFFFF);
        send_beat(1'b1, 24'hFFFFFF);
        send_beat(1'b0, 24'd50);
        send_beat(1'b0, 24'd150);
        repeat (8) send_beat(1'b0, 24'hFFFFFF);
        send_beat(1'b0, 24'd100);
        send_beat(1'b0, 24'hFFFFFF);
        send_beat(1'b1, 24'h800000);
        send_beat(1'b1, 24'h7FFFFF);

        configure(0, 0, 0);
        send_beat(1'b0, 24'hFFFFFF);
        send_beat(1'b1, 24'hFFFFFF);
        configure(65535, 1, 1023);
        send_beat(1'b0, 24'hFFFFFF);
        send_beat(1'b1, 24'h000001);
        configure(1, 65535, 1);
        send_beat(1'b0, 24'hFFFFFF);
        send_beat(1'b1, 24'hFFFFFF);
        send_beat(1'b1, 24'd5);

        for (int phase = 0; phase < 10; phase++)
        begin
            case (phase)
                0:       configure(800, 60, 48);
                1:       configure(65535, 65535, 1023);
                2:       configure(1, 1, 1);
                3:       configure(200, 3600, 12);
                default: configure($urandom_range(1, 65535), $urandom_range(1, 65535),
                                   $urandom_range(1, 1023));
            endcase
            if (phase == 4)
                hold_request = 3000;
            for (int i = 0; i < 83; i++)
                send_beat(($urandom_range(0, 1) == 1), random_power());
        end

        drain();
        repeat (200) @(negedge clk);
        $display("tb: %0d beats sent (%0d charge, %0d discharge) over 14 register settings",
                 beats_sent, charges_sent, beats_sent - charges_sent);
        $display("tb: with random gaps, back-pressure stalls and a long output hold");
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
